FILE: rtl/core/bped_pkg.sv
// Package for the button press event detector: sizes, configuration register
// indexes, the per-button phase code, the state memory entry and the saturating add.
// No dependencies.
package bped_pkg;

    localparam int NUM_BUTTONS = 4;
    localparam int BTN_W       = $clog2(NUM_BUTTONS);
    localparam int TIME_W      = 16;
    localparam int TICK_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [TICK_W-1:0] TICK_MS_RESET     = TICK_W'(5);
    localparam logic [TIME_W-1:0] DEBOUNCE_MS_RESET = TIME_W'(20);
    localparam logic [TIME_W-1:0] LONG_MS_RESET     = TIME_W'(3000);

    typedef logic [NUM_BUTTONS-1:0] btn_mask_t;
    typedef logic [BTN_W-1:0]       btn_idx_t;
    typedef logic [TIME_W-1:0]      press_time_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE_MASK = 3'd0,
        CFG_LEVEL_MASK  = 3'd1,
        CFG_TICK_MS     = 3'd2,
        CFG_DEBOUNCE_MS = 3'd3,
        CFG_LONG_MS     = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_RELEASED = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_HELD     = 2'd2,
        PH_LONG     = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        press_time_t press_time;
        logic        rel_clear;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{phase: PH_RELEASED, press_time: '0, rel_clear: 1'b1};

    // Adds one tick to a press time and stops at the top of the range.
    function automatic press_time_t grow(input press_time_t t, input logic [TICK_W-1:0] tick);
        logic [TIME_W:0] sum;
        sum = {1'b0, t} + (TIME_W+1)'(tick);
        return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    endfunction

endpackage

FILE: rtl/core/bped_if.sv
// Stream interfaces of the button press event detector: ticks in, events out.
// Depends on bped_pkg.
interface bped_tick_if;
    logic                valid;
    logic                ready;
    bped_pkg::btn_mask_t pin_levels;

    modport source (output valid, output pin_levels, input ready);
    modport sink   (input valid, input pin_levels, output ready);
endinterface

interface bped_event_if;
    logic                valid;
    logic                ready;
    bped_pkg::btn_mask_t short_press_events;
    bped_pkg::btn_mask_t long_press_events;
    bped_pkg::btn_mask_t release_events;

    modport source (output valid, output short_press_events, output long_press_events,
                    output release_events, input ready);
    modport sink   (input valid, input short_press_events, input long_press_events,
                    input release_events, output ready);
endinterface

FILE: rtl/core/button_press_event_detector.sv
// Top level of the button press event detector: per-button debounce, short,
// long and release events. Depends on bped_pkg and the interfaces in bped_if.sv.
//
//  channel   | kind           | content
//  ----------+----------------+------------------------------------------------
//  ticks     | valid/ready in | pin_levels, one transaction per timer tick
//  events    | valid/ready out| short, long and release event masks per tick
//  cfg_*     | write only     | cfg_we, cfg_index, cfg_data
//
// A tick makes one state memory read per button, one button per cycle through the
// single read port unless a stall holds it, read-modify-write over two stages.
// The next tick is taken in the cycle its predecessor issues its last read, before
// that one is written back; results leave through an output register.
// After reset every button reads as released with zero press time.
// A full output register with the sink stalled freezes both stages when the next
// result is ready to leave.
module button_press_event_detector (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bped_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bped_pkg::CFG_DATA_W-1:0]    cfg_data,
    bped_tick_if.sink                          ticks,
    bped_event_if.source                       events
);
    import bped_pkg::*;

    localparam btn_idx_t LAST_BTN = BTN_W'(NUM_BUTTONS - 1);

    // Configuration registers.
    btn_mask_t           enable_reg;
    btn_mask_t           level_reg;
    logic [TICK_W-1:0]   tick_reg;
    press_time_t         debounce_reg;
    press_time_t         long_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= '0;
            level_reg    <= '0;
            tick_reg     <= TICK_MS_RESET;
            debounce_reg <= DEBOUNCE_MS_RESET;
            long_reg     <= LONG_MS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLE_MASK: enable_reg   <= cfg_data[NUM_BUTTONS-1:0];
                CFG_LEVEL_MASK:  level_reg    <= cfg_data[NUM_BUTTONS-1:0];
                CFG_TICK_MS:     tick_reg     <= cfg_data[TICK_W-1:0];
                CFG_DEBOUNCE_MS: debounce_reg <= cfg_data[TIME_W-1:0];
                CFG_LONG_MS:     long_reg     <= cfg_data[TIME_W-1:0];
                default:         ;
            endcase
        end
    end

    // Issue stage: walks the buttons of the current tick.
    logic      busy_reg;
    btn_idx_t  idx_reg;
    btn_mask_t levels_reg;

    // Update stage: holds the button whose entry is coming out of the memory.
    logic      b_valid_reg;
    btn_idx_t  b_idx_reg;
    btn_mask_t b_levels_reg;

    // Event accumulation and output register.
    btn_mask_t acc_short_reg, acc_long_reg, acc_rel_reg;
    logic      out_valid_reg;
    btn_mask_t out_short_reg, out_long_reg, out_rel_reg;

    logic b_last;
    logic stall;
    logic advance;
    logic take_tick;
    logic rd_en;

    assign b_last    = (b_idx_reg == LAST_BTN);
    assign stall     = b_valid_reg && b_last && out_valid_reg && !events.ready;
    assign advance   = !stall;
    assign take_tick = ticks.valid && ticks.ready;
    assign rd_en     = advance && busy_reg;

    assign ticks.ready = advance && (!busy_reg || idx_reg == LAST_BTN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            b_valid_reg <= 1'b0;
            b_idx_reg   <= '0;
        end
        else if (advance)
        begin
            b_valid_reg <= busy_reg;
            b_idx_reg   <= idx_reg;
            if (take_tick)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (busy_reg)
            begin
                busy_reg <= (idx_reg != LAST_BTN);
                idx_reg  <= idx_reg + BTN_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_levels_reg <= levels_reg;
            if (take_tick)
            begin
                levels_reg <= ticks.pin_levels;
            end
        end
    end

    // State memory. Each entry is read once per tick by the issue stage and written
    // back by the update stage before its next read, so read and write of one entry
    // never overlap and no forwarding is needed.
    entry_t    mem [NUM_BUTTONS];
    entry_t    mem_rd_reg;
    btn_mask_t vld_reg;
    logic      vld_rd_reg;
    entry_t    wr_data;
    logic      wr_en;

    assign wr_en = b_valid_reg && advance;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_rd_reg <= mem[idx_reg];
        end
        if (wr_en)
        begin
            mem[b_idx_reg] <= wr_data;
        end
    end

    // Entries that were never written read as the reset state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                vld_rd_reg <= vld_reg[idx_reg];
            end
            if (wr_en)
            begin
                vld_reg[b_idx_reg] <= 1'b1;
            end
        end
    end

    // Per-button phase update.
    entry_t      cur;
    press_time_t grown;
    logic        active;
    logic        ev_short, ev_long, ev_rel;

    always_comb
    begin
        cur      = vld_rd_reg ? mem_rd_reg : ENTRY_RESET;
        grown    = grow(cur.press_time, tick_reg);
        active   = (b_levels_reg[b_idx_reg] == level_reg[b_idx_reg]);
        wr_data  = cur;
        ev_short = 1'b0;
        ev_long  = 1'b0;
        ev_rel   = 1'b0;
        if (enable_reg[b_idx_reg])
        begin
            if (cur.phase == PH_RELEASED)
            begin
                if (active)
                begin
                    wr_data.press_time = grown;
                    wr_data.phase      = PH_PRESSED;
                end
            end
            else if (!active)
            begin
                ev_rel             = !cur.rel_clear;
                wr_data.rel_clear  = 1'b1;
                wr_data.phase      = PH_RELEASED;
                wr_data.press_time = '0;
            end
            else
            begin
                case (cur.phase)
                    PH_PRESSED:
                    begin
                        wr_data.press_time = grown;
                        if (grown >= debounce_reg)
                        begin
                            ev_short          = 1'b1;
                            wr_data.rel_clear = 1'b0;
                            wr_data.phase     = PH_HELD;
                        end
                    end
                    PH_HELD:
                    begin
                        wr_data.press_time = grown;
                        if (grown >= long_reg)
                        begin
                            ev_long       = 1'b1;
                            wr_data.phase = PH_LONG;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Event bits collected over the buttons of one tick.
    btn_mask_t acc_short_next, acc_long_next, acc_rel_next;

    always_comb
    begin
        acc_short_next = (b_idx_reg == '0) ? '0 : acc_short_reg;
        acc_long_next  = (b_idx_reg == '0) ? '0 : acc_long_reg;
        acc_rel_next   = (b_idx_reg == '0) ? '0 : acc_rel_reg;
        acc_short_next[b_idx_reg] = ev_short;
        acc_long_next[b_idx_reg]  = ev_long;
        acc_rel_next[b_idx_reg]   = ev_rel;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            acc_short_reg <= acc_short_next;
            acc_long_reg  <= acc_long_next;
            acc_rel_reg   <= acc_rel_next;
        end
        if (wr_en && b_last)
        begin
            out_short_reg <= acc_short_next;
            out_long_reg  <= acc_long_next;
            out_rel_reg   <= acc_rel_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (wr_en && b_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (events.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign events.valid              = out_valid_reg;
    assign events.short_press_events = out_short_reg;
    assign events.long_press_events  = out_long_reg;
    assign events.release_events     = out_rel_reg;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the button press event detector: runs directed and random tick
// streams and checks every event transaction against its own button predictor.
// Depends on bped_pkg, the interfaces in bped_if.sv and button_press_event_detector.
module tb_top;
    import bped_pkg::*;

    typedef struct packed {
        btn_mask_t short_ev;
        btn_mask_t long_ev;
        btn_mask_t rel_ev;
    } event_set_t;

    typedef enum logic {ROW_CFG, ROW_TICK} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        btn_mask_t   en;
        btn_mask_t   lvl;
        logic [7:0]  tk;
        press_time_t deb;
        press_time_t lng;
        btn_mask_t   pins;
        logic        has_ev;
        event_set_t  ev;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bped_tick_if  tick_ch ();
    bped_event_if event_ch ();

    button_press_event_detector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ticks     (tick_ch),
        .events    (event_ch)
    );

    // Shadow copy of the settings and of every button's machine.
    btn_mask_t   cur_enable;
    btn_mask_t   cur_level;
    logic [7:0]  cur_tick;
    press_time_t cur_debounce;
    press_time_t cur_long;
    phase_t      btn_phase [NUM_BUTTONS];
    press_time_t btn_time [NUM_BUTTONS];
    logic        btn_released [NUM_BUTTONS];

    event_set_t expected_events [$];
    int         err_count = 0;
    int         src_idle_pct = 0;
    int         snk_idle_pct = 0;

    function automatic dir_row_t cfg_row(input btn_mask_t en, input btn_mask_t lvl,
                                         input logic [7:0] tk, input press_time_t deb,
                                         input press_time_t lng);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.en   = en;
        r.lvl  = lvl;
        r.tk   = tk;
        r.deb  = deb;
        r.lng  = lng;
        return r;
    endfunction

    function automatic dir_row_t tick_row(input btn_mask_t pins);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_TICK;
        r.pins = pins;
        return r;
    endfunction

    // A tick whose events are known to be all clear.
    function automatic dir_row_t quiet_row(input btn_mask_t pins);
        dir_row_t r;
        r        = tick_row(pins);
        r.has_ev = 1'b1;
        return r;
    endfunction

    localparam int DIR_ROWS = 23;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // Nothing is watched after reset.
        quiet_row(4'hF), quiet_row(4'h0),
        // Active high, zero debounce, short long-press time.
        cfg_row(4'hF, 4'hF, 8'd5, 16'd0, 16'd15),
        tick_row(4'hF), tick_row(4'hF), tick_row(4'hF), tick_row(4'hF),
        tick_row(4'h0), tick_row(4'h5), tick_row(4'h0), tick_row(4'h5),
        // Buttons 0 and 2 are frozen mid-press while disabled.
        cfg_row(4'hA, 4'h0, 8'd255, 16'hFFFF, 16'hFFFF),
        tick_row(4'h0), tick_row(4'h0), tick_row(4'hF), tick_row(4'h5),
        // A zero tick length: press time never grows.
        cfg_row(4'hF, 4'h5, 8'd0, 16'd0, 16'd0),
        tick_row(4'h5), tick_row(4'h5), tick_row(4'h5), tick_row(4'hA),
        tick_row(4'h5), tick_row(4'h5)
    };

    function automatic press_time_t add_tick(input press_time_t t);
        logic [TIME_W:0] total;
        total = {1'b0, t} + {{(TIME_W-7){1'b0}}, cur_tick};
        return (total > {1'b0, {TIME_W{1'b1}}}) ? {TIME_W{1'b1}} : total[TIME_W-1:0];
    endfunction

    function automatic event_set_t advance_buttons(input btn_mask_t pins);
        event_set_t ev;
        logic       on;
        ev = '0;
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            if (!cur_enable[b])
                continue;
            on = (pins[b] == cur_level[b]);
            if (btn_phase[b] == PH_RELEASED)
            begin
                if (on)
                begin
                    btn_time[b]  = add_tick(btn_time[b]);
                    btn_phase[b] = PH_PRESSED;
                end
            end
            else if (!on)
            begin
                if (!btn_released[b])
                    ev.rel_ev[b] = 1'b1;
                btn_released[b] = 1'b1;
                btn_phase[b]    = PH_RELEASED;
                btn_time[b]     = '0;
            end
            else if (btn_phase[b] == PH_PRESSED)
            begin
                btn_time[b] = add_tick(btn_time[b]);
                if (btn_time[b] >= cur_debounce)
                begin
                    ev.short_ev[b]  = 1'b1;
                    btn_released[b] = 1'b0;
                    btn_phase[b]    = PH_HELD;
                end
            end
            else if (btn_phase[b] == PH_HELD)
            begin
                btn_time[b] = add_tick(btn_time[b]);
                if (btn_time[b] >= cur_long)
                begin
                    ev.long_ev[b] = 1'b1;
                    btn_phase[b]  = PH_LONG;
                end
            end
        end
        return ev;
    endfunction

    function automatic void note_failure(input string msg);
        if (err_count < 10)
            $display("%s", msg);
        err_count++;
    endfunction

    // Called just after a falling edge; returns just after the falling edge that
    // follows the accepting rising edge, with valid still high.
    task automatic send_tick(input btn_mask_t pins, input logic has_ev, input event_set_t ev);
        event_set_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(negedge clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.pin_levels <= pins;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        predicted = advance_buttons(pins);
        expected_events.push_back(has_ev ? ev : predicted);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (expected_events.size() != 0);
    endtask

    task automatic cfg_reg_write(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_ENABLE_MASK: cur_enable   = val[NUM_BUTTONS-1:0];
            CFG_LEVEL_MASK:  cur_level    = val[NUM_BUTTONS-1:0];
            CFG_TICK_MS:     cur_tick     = val[TICK_W-1:0];
            CFG_DEBOUNCE_MS: cur_debounce = val;
            CFG_LONG_MS:     cur_long     = val;
            default:         ;
        endcase
        @(negedge clk);
    endtask

    task automatic load_settings(input btn_mask_t en, input btn_mask_t lvl,
                                 input logic [7:0] tk, input press_time_t deb,
                                 input press_time_t lng);
        cfg_reg_write(CFG_ENABLE_MASK, CFG_DATA_W'(en));
        cfg_reg_write(CFG_LEVEL_MASK, CFG_DATA_W'(lvl));
        cfg_reg_write(CFG_TICK_MS, CFG_DATA_W'(tk));
        cfg_reg_write(CFG_DEBOUNCE_MS, deb);
        cfg_reg_write(CFG_LONG_MS, lng);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    initial
    begin
        event_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            event_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_events
        event_set_t want;
        if (rst_n && event_ch.valid && event_ch.ready)
        begin
            if (expected_events.size() == 0)
                note_failure($sformatf("unexpected event transaction: s=%h l=%h r=%h",
                                       event_ch.short_press_events,
                                       event_ch.long_press_events,
                                       event_ch.release_events));
            else
            begin
                want = expected_events.pop_front();
                if (event_ch.short_press_events !== want.short_ev
                    || event_ch.long_press_events !== want.long_ev
                    || event_ch.release_events !== want.rel_ev)
                    note_failure($sformatf(
                        "event mismatch: expected s=%h l=%h r=%h, got s=%h l=%h r=%h",
                        want.short_ev, want.long_ev, want.rel_ev,
                        event_ch.short_press_events, event_ch.long_press_events,
                        event_ch.release_events));
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        btn_mask_t   pins;
        btn_mask_t   en;
        btn_mask_t   lvl;
        logic [7:0]  tk;
        press_time_t deb;
        press_time_t lng;
        int          n_items;
        int          noise_pct;
        int          t_short;
        int          t_long;
        int          len;
        logic        seg_on [NUM_BUTTONS];
        int          seg_left [NUM_BUTTONS];

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        tick_ch.valid      = 1'b0;
        tick_ch.pin_levels = '0;
        cur_enable         = '0;
        cur_level          = '0;
        cur_tick           = 8'd5;
        cur_debounce       = 16'd20;
        cur_long           = 16'd3000;
        for (int b = 0; b < NUM_BUTTONS; b++)
        begin
            btn_phase[b]    = PH_RELEASED;
            btn_time[b]     = '0;
            btn_released[b] = 1'b1;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        src_idle_pct = 11;
        snk_idle_pct = 53;
        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_CFG)
            begin
                tick_ch.valid <= 1'b0;
                wait_drained();
                load_settings(dir_rows[r].en, dir_rows[r].lvl, dir_rows[r].tk,
                              dir_rows[r].deb, dir_rows[r].lng);
            end
            else
                send_tick(dir_rows[r].pins, dir_rows[r].has_ev, dir_rows[r].ev);
        end
        tick_ch.valid <= 1'b0;
        wait_drained();

        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph < 3)
            begin
                src_idle_pct = 11;
                snk_idle_pct = 53;
            end
            else if (ph < 6)
            begin
                src_idle_pct = 53;
                snk_idle_pct = 11;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end

            en        = btn_mask_t'($urandom_range(1, 15));
            lvl       = btn_mask_t'($urandom_range(0, 15));
            n_items   = 100;
            noise_pct = 8;
            case (ph)
                2:
                begin
                    // Long holds at the largest tick drive press time into saturation.
                    en        = 4'hF;
                    tk        = 8'd255;
                    deb       = 16'hFFFF;
                    lng       = 16'hFFFF;
                    n_items   = 320;
                    noise_pct = 0;
                end
                5:
                begin
                    tk  = 8'd0;
                    deb = 16'd0;
                    lng = press_time_t'($urandom_range(0, 1));
                end
                7:
                begin
                    tk  = 8'd1;
                    deb = 16'd0;
                    lng = 16'hFFFF;
                end
                default:
                begin
                    tk  = 8'($urandom_range(1, 40));
                    deb = press_time_t'(tk * $urandom_range(0, 6));
                    lng = deb + press_time_t'(tk * $urandom_range(0, 30));
                end
            endcase
            load_settings(en, lvl, tk, deb, lng);

            if (tk == 0)
            begin
                t_short = 2;
                t_long  = 3;
            end
            else
            begin
                t_short = deb / tk + 2;
                t_long  = lng / tk + 2;
            end
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                seg_on[b]   = 1'b1;
                seg_left[b] = 0;
            end

            for (int n = 0; n < n_items; n++)
            begin
                if (n == n_items / 2)
                begin
                    tick_ch.valid <= 1'b0;
                    wait_drained();
                end
                // Each button alternates between a hold of a chosen length and a short gap.
                for (int b = 0; b < NUM_BUTTONS; b++)
                begin
                    if (seg_left[b] == 0)
                    begin
                        seg_on[b] = !seg_on[b];
                        if (!seg_on[b])
                            len = $urandom_range(1, 4);
                        else
                        begin
                            case ($urandom_range(3))
                                0:       len = $urandom_range(1, 2);
                                1:       len = $urandom_range(1, t_short + 1);
                                2:       len = $urandom_range(t_long - 1, t_long + 3);
                                default: len = $urandom_range(1, t_long + 8);
                            endcase
                            if (len > 300)
                                len = 300;
                        end
                        seg_left[b] = len;
                    end
                    if (!en[b])
                        pins[b] = 1'($urandom_range(1));
                    else
                        pins[b] = seg_on[b] ? lvl[b] : ~lvl[b];
                    seg_left[b]--;
                end
                if ($urandom_range(99) < noise_pct)
                    pins[$urandom_range(NUM_BUTTONS - 1)] ^= 1'b1;
                send_tick(pins, 1'b0, '0);
            end
            tick_ch.valid <= 1'b0;
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (err_count == 0 && expected_events.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
